// ===== hw/rtl/lane_neighbour_gap_checker_macros.svh =====
// Assertion macros for the lane neighbour gap checker.
`ifndef LANE_NEIGHBOUR_GAP_CHECKER_MACROS_SVH
`define LANE_NEIGHBOUR_GAP_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LNGC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lngc: assertion failed");
// Next-cycle implication, disabled during reset.
`define LNGC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lngc: assertion failed");
`else
`define LNGC_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define LNGC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/lngc_pkg.sv =====
// Types and constants shared by the lane neighbour gap checker.
`default_nettype none
package lngc_pkg;

  // Field widths
  localparam int PosW     = 24;
  localparam int SpeedW   = 15;
  localparam int LaneW    = 4;
  localparam int TgtW     = 2;
  localparam int LaheadW  = 12;
  localparam int FracW    = 8;
  localparam int ProdW    = LaheadW + SpeedW;
  localparam int StepW    = ProdW - FracW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Road geometry
  localparam int NumLanes = 3;

  // Slot layout
  localparam int NumSlots        = 5;
  localparam int SlotFront       = 0;
  localparam int SlotLeftAhead   = 1;
  localparam int SlotLeftBehind  = 2;
  localparam int SlotRightAhead  = 3;
  localparam int SlotRightBehind = 4;

  // Register reset values
  localparam logic [TgtW-1:0]    TargetLaneRst = TgtW'(1);
  localparam logic [PosW-1:0]    EgoPosRst     = '0;
  localparam logic [LaheadW-1:0] LookaheadRst  = '0;
  localparam logic [PosW-1:0]    NearLimitRst  = PosW'(25600);
  localparam logic [PosW-1:0]    FrontGapRst   = PosW'(10240);
  localparam logic [PosW-1:0]    RearGapRst    = PosW'(5120);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_LANE    = 3'd0,
    REG_EGO_POSITION   = 3'd1,
    REG_LOOKAHEAD_TIME = 3'd2,
    REG_NEAR_LIMIT     = 3'd3,
    REG_FRONT_GAP      = 3'd4,
    REG_REAR_GAP       = 3'd5
  } cfg_reg_e;

  // One tracked vehicle
  typedef struct packed {
    logic [PosW-1:0]   car_position;
    logic [SpeedW-1:0] car_speed;
    logic [LaneW-1:0]  car_lane;
    logic              last_car;
  } car_t;

  // One gap report
  typedef struct packed {
    logic            front_free;
    logic            left_free;
    logic            right_free;
    logic            front_found;
    logic [PosW-1:0] front_position;
  } gap_t;

  // Lane class of a vehicle relative to the target lane
  typedef struct packed {
    logic is_target;
    logic is_left;
    logic is_right;
  } lane_cls_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lngc_chan_if.sv =====
// Valid/ready channel carrying one payload per request.
`default_nettype none
interface lngc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lane_neighbour_gap_checker.sv =====
// Lane neighbour gap checker: a three-stage pipeline with the slot store and the report register.
//
// Takes one vehicle request per cycle on car_i when car_i.ready allows and, on the request
// marked last_car, delivers one gap report on gap_o after stage three. Stage one registers the
// request and forms the lookahead product (12 x 15 bit) and the near-range test;
// stage two adds the predicted advance with saturation; stage three compares the
// prediction against the five slot registers and the gap thresholds, updates the
// slots and loads the report register. Requests keep flowing while a report waits;
// the pipeline stalls only when a last_car request reaches stage three while the
// previous report is still untaken. Configuration is written through cfg_we_i with
// no wait state, and must only change while the pipeline is empty.
`default_nettype none
`include "lane_neighbour_gap_checker_macros.svh"
module lane_neighbour_gap_checker (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [lngc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire [lngc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  lngc_chan_if.sink                       car_i,
  lngc_chan_if.source                     gap_o
);

  localparam int PosW   = lngc_pkg::PosW;
  localparam int NSlots = lngc_pkg::NumSlots;

  // Configuration registers
  logic [lngc_pkg::TgtW-1:0]    target_lane_q;
  logic [PosW-1:0]              ego_pos_q;
  logic [lngc_pkg::LaheadW-1:0] lookahead_q;
  logic [PosW-1:0]              near_limit_q;
  logic [PosW-1:0]              front_gap_q;
  logic [PosW-1:0]              rear_gap_q;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_lane_q <= lngc_pkg::TargetLaneRst;
      ego_pos_q     <= lngc_pkg::EgoPosRst;
      lookahead_q   <= lngc_pkg::LookaheadRst;
      near_limit_q  <= lngc_pkg::NearLimitRst;
      front_gap_q   <= lngc_pkg::FrontGapRst;
      rear_gap_q    <= lngc_pkg::RearGapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lngc_pkg::REG_TARGET_LANE:    target_lane_q <= cfg_wdata_i[lngc_pkg::TgtW-1:0];
        lngc_pkg::REG_EGO_POSITION:   ego_pos_q     <= cfg_wdata_i[PosW-1:0];
        lngc_pkg::REG_LOOKAHEAD_TIME: lookahead_q   <= cfg_wdata_i[lngc_pkg::LaheadW-1:0];
        lngc_pkg::REG_NEAR_LIMIT:     near_limit_q  <= cfg_wdata_i[PosW-1:0];
        lngc_pkg::REG_FRONT_GAP:      front_gap_q   <= cfg_wdata_i[PosW-1:0];
        lngc_pkg::REG_REAR_GAP:       rear_gap_q    <= cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s3_last_q;
  logic out_v_q;
  logic s3_adv, s2_move, s1_move, in_take;

  assign s3_adv  = s3_v_q && !(s3_last_q && out_v_q && !gap_o.ready);
  assign s2_move = s2_v_q && (!s3_v_q || s3_adv);
  assign s1_move = s1_v_q && (!s2_v_q || s2_move);
  assign car_i.ready = !s1_v_q || s1_move;
  assign in_take = car_i.valid && car_i.ready;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (s2_move) begin
        s2_v_q <= 1'b0;
      end
      if (s2_move) begin
        s3_v_q <= 1'b1;
      end else if (s3_adv) begin
        s3_v_q <= 1'b0;
      end
    end
  end

  // Stage one: request register
  lngc_pkg::car_t s1_car_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_car_q <= car_i.data;
    end
  end

  // Stage one: product, near-range test and lane class
  logic [lngc_pkg::ProdW-1:0] s1_prod;
  logic                       s1_pos_ge;
  logic [PosW-1:0]            s1_dist;
  logic                       s1_near;
  logic [lngc_pkg::LaneW-1:0] tgt_lane_ext;
  lngc_pkg::lane_cls_t        s1_cls;

  assign s1_prod   = lngc_pkg::ProdW'(lookahead_q) * lngc_pkg::ProdW'(s1_car_q.car_speed);
  assign s1_pos_ge = s1_car_q.car_position >= ego_pos_q;
  assign s1_dist   = s1_pos_ge ? (s1_car_q.car_position - ego_pos_q)
                               : (ego_pos_q - s1_car_q.car_position);
  assign s1_near   = s1_dist < near_limit_q;
  assign tgt_lane_ext = lngc_pkg::LaneW'(target_lane_q);

  always_comb begin
    s1_cls.is_target = s1_near && (s1_car_q.car_lane == tgt_lane_ext);
    s1_cls.is_left   = s1_near && (target_lane_q != '0)
                       && (s1_car_q.car_lane == tgt_lane_ext - lngc_pkg::LaneW'(1));
    s1_cls.is_right  = s1_near
                       && (s1_car_q.car_lane == tgt_lane_ext + lngc_pkg::LaneW'(1));
  end

  // Stage two registers
  logic [PosW-1:0]            s2_pos_q;
  logic [lngc_pkg::StepW-1:0] s2_step_q;
  lngc_pkg::lane_cls_t        s2_cls_q;
  logic                       s2_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_pos_q  <= s1_car_q.car_position;
      s2_step_q <= s1_prod[lngc_pkg::ProdW-1:lngc_pkg::FracW];
      s2_cls_q  <= s1_cls;
      s2_last_q <= s1_car_q.last_car;
    end
  end

  // Stage two: predicted position, saturated
  logic [PosW:0]   s2_sum;
  logic [PosW-1:0] s2_pred;

  assign s2_sum  = {1'b0, s2_pos_q} + (PosW+1)'(s2_step_q);
  assign s2_pred = s2_sum[PosW] ? '1 : s2_sum[PosW-1:0];

  // Stage three registers
  logic [PosW-1:0]     s3_pred_q;
  lngc_pkg::lane_cls_t s3_cls_q;

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      s3_pred_q <= s2_pred;
      s3_cls_q  <= s2_cls_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Slot store: position and valid
  logic [PosW-1:0]   slot_p_q [NSlots];
  logic [NSlots-1:0] slot_v_q;

  // Stage three: compare against ego, gap thresholds and held slots
  logic          gt_ego, ge_ego;
  logic [PosW:0] front_thr;
  logic [NSlots-1:0] upd;
  logic [PosW-1:0]   nxt_p [NSlots];
  logic [NSlots-1:0] nxt_v;
  logic [NSlots-1:0] blk;
  logic [NSlots-1:0] slot_v_d;
  logic              right_exists;
  lngc_pkg::gap_t    rep;

  assign gt_ego     = s3_pred_q > ego_pos_q;
  assign ge_ego     = s3_pred_q >= ego_pos_q;
  assign front_thr  = {1'b0, ego_pos_q} + {1'b0, front_gap_q};
  assign right_exists = (int'(target_lane_q) + 1) < lngc_pkg::NumLanes;

  // Decide which slot the vehicle replaces; first vehicle wins ties
  always_comb begin
    upd = '0;
    upd[lngc_pkg::SlotFront] = s3_cls_q.is_target && gt_ego
      && (!slot_v_q[lngc_pkg::SlotFront] || slot_p_q[lngc_pkg::SlotFront] > s3_pred_q);
    upd[lngc_pkg::SlotLeftAhead] = s3_cls_q.is_left && ge_ego
      && (!slot_v_q[lngc_pkg::SlotLeftAhead]
          || slot_p_q[lngc_pkg::SlotLeftAhead] > s3_pred_q);
    upd[lngc_pkg::SlotLeftBehind] = s3_cls_q.is_left && !ge_ego
      && (!slot_v_q[lngc_pkg::SlotLeftBehind]
          || slot_p_q[lngc_pkg::SlotLeftBehind] < s3_pred_q);
    upd[lngc_pkg::SlotRightAhead] = s3_cls_q.is_right && ge_ego
      && (!slot_v_q[lngc_pkg::SlotRightAhead]
          || slot_p_q[lngc_pkg::SlotRightAhead] > s3_pred_q);
    upd[lngc_pkg::SlotRightBehind] = s3_cls_q.is_right && !ge_ego
      && (!slot_v_q[lngc_pkg::SlotRightBehind]
          || slot_p_q[lngc_pkg::SlotRightBehind] < s3_pred_q);
    upd = upd & {NSlots{s3_adv}};
  end

  // Form the updated slot contents
  always_comb begin
    for (int s = 0; s < NSlots; s++) begin
      nxt_p[s] = upd[s] ? s3_pred_q : slot_p_q[s];
      nxt_v[s] = upd[s] | slot_v_q[s];
    end
    // Drop all slots once the frame is reported
    slot_v_d = (s3_adv && s3_last_q) ? '0 : nxt_v;
  end

  // Test each updated slot against its gap threshold with the current settings
  always_comb begin
    for (int s = 0; s < NSlots; s++) begin
      blk[s] = {1'b0, nxt_p[s]} < front_thr;
    end
    blk[lngc_pkg::SlotLeftBehind] =
      ({1'b0, nxt_p[lngc_pkg::SlotLeftBehind]} + {1'b0, rear_gap_q}) > {1'b0, ego_pos_q};
    blk[lngc_pkg::SlotRightBehind] =
      ({1'b0, nxt_p[lngc_pkg::SlotRightBehind]} + {1'b0, rear_gap_q}) > {1'b0, ego_pos_q};
  end

  // Build the report from the updated slots
  always_comb begin
    rep.front_free  = !(nxt_v[lngc_pkg::SlotFront] && blk[lngc_pkg::SlotFront]);
    rep.left_free   = (target_lane_q != '0)
      && !(nxt_v[lngc_pkg::SlotLeftAhead] && blk[lngc_pkg::SlotLeftAhead])
      && !(nxt_v[lngc_pkg::SlotLeftBehind] && blk[lngc_pkg::SlotLeftBehind]);
    rep.right_free  = right_exists
      && !(nxt_v[lngc_pkg::SlotRightAhead] && blk[lngc_pkg::SlotRightAhead])
      && !(nxt_v[lngc_pkg::SlotRightBehind] && blk[lngc_pkg::SlotRightBehind]);
    rep.front_found = nxt_v[lngc_pkg::SlotFront];
    rep.front_position = nxt_v[lngc_pkg::SlotFront] ? nxt_p[lngc_pkg::SlotFront] : '0;
  end

  // Hold slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q <= '0;
    end else begin
      slot_v_q <= slot_v_d;
    end
  end

  // Hold slot payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NSlots; s++) begin
      slot_p_q[s] <= nxt_p[s];
    end
  end

  // Report register
  lngc_pkg::gap_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s3_adv && s3_last_q) begin
      out_v_q <= 1'b1;
    end else if (gap_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv && s3_last_q) begin
      out_q <= rep;
    end
  end

  assign gap_o.valid = out_v_q;
  assign gap_o.data  = out_q;

  // Checks
  `LNGC_ASSERT_NEXT(a_report_loads, clk_i, rst_ni, s3_adv && s3_last_q, out_v_q)
  `LNGC_ASSERT_NEXT(a_report_clears, clk_i, rst_ni, s3_adv && s3_last_q, slot_v_q == '0)
  `LNGC_ASSERT_NEXT(a_slots_hold, clk_i, rst_ni, !s3_adv, $stable(slot_v_q))
  `LNGC_ASSERT_NEXT(a_stall_keeps, clk_i, rst_ni, s3_v_q && !s3_adv, s3_v_q)
  `LNGC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, s3_v_q && !s3_adv, out_v_q && s3_last_q)

endmodule
`default_nettype wire
